FILE: design/pwlw_pkg.sv
`timescale 1ns / 1ps
package pwlw_pkg;

    localparam int MAX_ANCHORS = 16;
    localparam int IDX_W       = $clog2(MAX_ANCHORS);
    localparam int CNT_W       = $clog2(MAX_ANCHORS + 1);
    localparam int FRAC_BITS   = 16;
    localparam int TICK_BITS   = 32;
    localparam int POS_W       = 48;
    // offset from the segment start, one bit above a position
    localparam int D_W         = POS_W + 1;
    // offset times slope numerator
    localparam int PROD_W      = D_W + TICK_BITS;
    localparam int WIDE_W      = PROD_W + 1;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_FORWARD = 2'd1;
    localparam logic [1:0] OP_INVERSE = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DROPPED   = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_SATURATED = 2'd3;

    localparam logic [0:0] REG_NUMERATOR   = 1'b0;
    localparam logic [0:0] REG_DENOMINATOR = 1'b1;

endpackage

FILE: design/pwlw_table.sv
`timescale 1ns / 1ps
module pwlw_table
    import pwlw_pkg::*;
(
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  logic [TICK_BITS-1:0] wr_source,
    input  logic [TICK_BITS-1:0] wr_target,
    input  logic [IDX_W-1:0]     rd_addr,
    output logic [TICK_BITS-1:0] rd_source,
    output logic [TICK_BITS-1:0] rd_target
);

    logic [TICK_BITS-1:0] source_reg [MAX_ANCHORS];
    logic [TICK_BITS-1:0] target_reg [MAX_ANCHORS];

    // anchor append
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            source_reg[wr_addr] <= wr_source;
            target_reg[wr_addr] <= wr_target;
        end
    end

    // single read port
    assign rd_source = source_reg[rd_addr];
    assign rd_target = target_reg[rd_addr];

endmodule

FILE: design/pwlw_mul.sv
`timescale 1ns / 1ps
module pwlw_mul
    import pwlw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [D_W-1:0]       mcand,
    input  logic [TICK_BITS-1:0] mplier,
    output logic                 done,
    output logic [PROD_W-1:0]    product
);

    localparam int HI_W  = D_W + 1;
    localparam int CNT_B = $clog2(TICK_BITS);

    logic [HI_W+TICK_BITS-1:0] p_reg;
    logic [D_W-1:0]            mcand_reg;
    logic [CNT_B-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [HI_W-1:0]           sum;

    // one add per multiplier bit, then shift right
    assign sum = p_reg[HI_W+TICK_BITS-1:TICK_BITS]
               + (p_reg[0] ? {1'b0, mcand_reg} : {HI_W{1'b0}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                p_reg     <= {{HI_W{1'b0}}, mplier};
                mcand_reg <= mcand;
                cnt_reg   <= CNT_B'(TICK_BITS - 1);
                busy_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                p_reg   <= {1'b0, sum, p_reg[TICK_BITS-1:1]};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign product = p_reg[PROD_W-1:0];

endmodule

FILE: design/pwlw_div.sv
`timescale 1ns / 1ps
module pwlw_div
    import pwlw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [PROD_W-1:0]    num,
    input  logic [TICK_BITS-1:0] den,
    output logic                 done,
    output logic [PROD_W-1:0]    quot,
    output logic [TICK_BITS-1:0] rem
);

    localparam int CNT_B = $clog2(PROD_W);

    logic [PROD_W-1:0]    n_reg;
    logic [TICK_BITS-1:0] r_reg;
    logic [TICK_BITS-1:0] d_reg;
    logic [CNT_B-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [TICK_BITS:0]   trial;
    logic                 ge;
    logic [TICK_BITS:0]   diff;

    // restoring step: one quotient bit per cycle
    assign trial = {r_reg, n_reg[PROD_W-1]};
    assign ge    = trial >= {1'b0, d_reg};
    assign diff  = trial - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                n_reg    <= num;
                d_reg    <= den;
                r_reg    <= '0;
                cnt_reg  <= CNT_B'(PROD_W - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                r_reg   <= ge ? diff[TICK_BITS-1:0] : trial[TICK_BITS-1:0];
                n_reg   <= {n_reg[PROD_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = n_reg;
    assign rem  = r_reg;

endmodule

FILE: design/piecewise_linear_warp_map.sv
`timescale 1ns / 1ps
// A clear offers its result beat in the cycle after the input beat; a load passes
// through S_LOAD before S_OUT. A query steps through the segment search, the
// previous anchor, setup, the shift-add multiply, the restoring divide and the
// final add. One beat in flight: the input stalls until the result beat is
// taken, and the next input beat is accepted in the cycle after that.
// Reset (rst_n, async, low) empties the anchor table and sets both stretch registers to 1.
module piecewise_linear_warp_map
    import pwlw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [0:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           operation,
    input  logic [TICK_BITS-1:0] anchor_source,
    input  logic [TICK_BITS-1:0] anchor_target,
    input  logic signed [POS_W-1:0] position,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [POS_W-1:0] mapped_position,
    output logic [4:0]           segment_index,
    output logic                 inexact,
    output logic [1:0]           status
);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_SEARCH, S_PREV, S_SETUP, S_MUL, S_DIV, S_FINAL, S_OUT
    } state_t;

    localparam logic [WIDE_W-1:0] POS_LIMIT = WIDE_W'((64'd1 << (POS_W - 1)) - 1);
    localparam logic [WIDE_W-1:0] NEG_LIMIT = WIDE_W'(64'd1 << (POS_W - 1));

    state_t               state_reg;
    logic [31:0]          num_reg, den_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     k_reg;
    logic                 fwd_reg;
    logic                 neg_reg;
    logic [POS_W-1:0]     mag_reg;
    logic [TICK_BITS-1:0] src_in_reg, tgt_in_reg;
    logic [TICK_BITS-1:0] hi_key_reg, hi_val_reg, lo_key_reg, lo_val_reg;
    logic                 dneg_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [POS_W-1:0]     out_pos_reg;
    logic [4:0]           out_seg_reg;
    logic                 out_inex_reg;
    logic [1:0]           out_st_reg;

    logic [IDX_W-1:0]     rd_addr;
    logic [TICK_BITS-1:0] rd_source, rd_target, rd_key, rd_val;
    logic                 wr_en;
    logic                 mul_start_reg, mul_done, div_start_reg, div_done;
    logic [D_W-1:0]       d_next;
    logic [TICK_BITS-1:0] f_next, g_next;
    logic [D_W-1:0]       d_reg;
    logic [TICK_BITS-1:0] f_reg, g_reg;
    logic [PROD_W-1:0]    product, quot;
    logic [TICK_BITS-1:0] rem;
    logic                 key_hit;
    logic                 load_drop;
    logic [POS_W-1:0]     a_pos, b_pos;
    logic [WIDE_W-1:0]    q_ext, b_ext, res_pos, q_up, res_neg;
    logic [POS_W-1:0]     fin_pos;
    logic                 fin_sat;
    logic [POS_W-1:0]     mag_in;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    // table read address follows the sequencer step
    always_comb
    begin
        unique case (state_reg)
            S_PREV:  rd_addr = IDX_W'(k_reg - 1'b1);
            S_LOAD:  rd_addr = IDX_W'(count_reg - 1'b1);
            default: rd_addr = k_reg[IDX_W-1:0];
        endcase
    end

    assign rd_key = fwd_reg ? rd_source : rd_target;
    assign rd_val = fwd_reg ? rd_target : rd_source;

    // append rule: strictly above the last point in both coordinates
    assign load_drop = (count_reg != '0)
                     ? ((src_in_reg <= rd_source) || (tgt_in_reg <= rd_target))
                     : ((src_in_reg == '0) || (tgt_in_reg == '0));
    assign wr_en = (state_reg == S_LOAD) && !load_drop
                 && (count_reg < CNT_W'(MAX_ANCHORS));

    pwlw_table u_table (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (count_reg[IDX_W-1:0]),
        .wr_source (src_in_reg),
        .wr_target (tgt_in_reg),
        .rd_addr   (rd_addr),
        .rd_source (rd_source),
        .rd_target (rd_target)
    );

    // search compare: position at or past this anchor
    assign key_hit = (k_reg < count_reg) && !neg_reg
                   && (mag_reg >= {rd_key, FRAC_BITS'(0)});

    // segment slope and offset
    assign a_pos = {lo_key_reg, FRAC_BITS'(0)};
    always_comb
    begin
        if (k_reg >= count_reg)
        begin
            f_next = fwd_reg ? num_reg : den_reg;
            g_next = fwd_reg ? den_reg : num_reg;
        end
        else
        begin
            f_next = hi_val_reg - lo_val_reg;
            g_next = hi_key_reg - lo_key_reg;
        end
        if (neg_reg)
            d_next = {1'b0, mag_reg} + {1'b0, a_pos};
        else if (mag_reg >= a_pos)
            d_next = {1'b0, mag_reg} - {1'b0, a_pos};
        else
            d_next = {1'b0, a_pos} - {1'b0, mag_reg};
    end

    pwlw_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .mcand   (d_reg),
        .mplier  (f_reg),
        .done    (mul_done),
        .product (product)
    );

    pwlw_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (prod_reg),
        .den   (g_reg),
        .done  (div_done),
        .quot  (quot),
        .rem   (rem)
    );

    // final add or subtract with saturation
    assign b_pos   = {lo_val_reg, FRAC_BITS'(0)};
    assign q_ext   = {1'b0, quot};
    assign b_ext   = WIDE_W'(b_pos);
    assign res_pos = b_ext + q_ext;
    assign q_up    = q_ext + WIDE_W'(rem != '0);
    assign res_neg = (q_up > b_ext) ? (q_up - b_ext) : (b_ext - q_up);
    always_comb
    begin
        if (!dneg_reg)
        begin
            fin_sat = res_pos > POS_LIMIT;
            fin_pos = fin_sat ? POS_LIMIT[POS_W-1:0] : res_pos[POS_W-1:0];
        end
        else if (q_up > b_ext)
        begin
            fin_sat = res_neg > NEG_LIMIT;
            fin_pos = fin_sat ? NEG_LIMIT[POS_W-1:0] : POS_W'(0) - res_neg[POS_W-1:0];
        end
        else
        begin
            fin_sat = res_neg > POS_LIMIT;
            fin_pos = fin_sat ? POS_LIMIT[POS_W-1:0] : res_neg[POS_W-1:0];
        end
    end

    assign mag_in = position[POS_W-1] ? (POS_W'(0) - position) : position;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            num_reg       <= 32'd1;
            den_reg       <= 32'd1;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_NUMERATOR:   num_reg <= (cfg_data == '0) ? 32'd1 : cfg_data;
                    REG_DENOMINATOR: den_reg <= (cfg_data == '0) ? 32'd1 : cfg_data;
                    default:         num_reg <= num_reg;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        src_in_reg <= anchor_source;
                        tgt_in_reg <= anchor_target;
                        fwd_reg    <= (operation == OP_FORWARD);
                        neg_reg    <= position[POS_W-1];
                        mag_reg    <= mag_in;
                        k_reg      <= '0;
                        unique case (operation)
                            OP_LOAD:
                                state_reg <= S_LOAD;
                            OP_CLEAR:
                            begin
                                count_reg    <= '0;
                                out_pos_reg  <= '0;
                                out_seg_reg  <= '0;
                                out_inex_reg <= 1'b0;
                                out_st_reg   <= ST_OK;
                                state_reg    <= S_OUT;
                            end
                            default:
                                state_reg <= S_SEARCH;
                        endcase
                    end
                end
                S_LOAD:
                begin
                    out_pos_reg  <= '0;
                    out_inex_reg <= 1'b0;
                    if (load_drop)
                    begin
                        out_st_reg  <= ST_DROPPED;
                        out_seg_reg <= 5'(count_reg);
                    end
                    else if (!wr_en)
                    begin
                        out_st_reg  <= ST_FULL;
                        out_seg_reg <= 5'(count_reg);
                    end
                    else
                    begin
                        out_st_reg  <= ST_OK;
                        out_seg_reg <= 5'(count_reg + 1'b1);
                        count_reg   <= count_reg + 1'b1;
                    end
                    state_reg <= S_OUT;
                end
                S_SEARCH:
                begin
                    if (key_hit)
                        k_reg <= k_reg + 1'b1;
                    else
                    begin
                        hi_key_reg <= rd_key;
                        hi_val_reg <= rd_val;
                        state_reg  <= S_PREV;
                    end
                end
                S_PREV:
                begin
                    lo_key_reg <= (k_reg == '0) ? '0 : rd_key;
                    lo_val_reg <= (k_reg == '0) ? '0 : rd_val;
                    state_reg  <= S_SETUP;
                end
                S_SETUP:
                begin
                    d_reg         <= d_next;
                    f_reg         <= f_next;
                    g_reg         <= (g_next == '0) ? TICK_BITS'(1) : g_next;
                    dneg_reg      <= neg_reg || (mag_reg < a_pos);
                    mul_start_reg <= 1'b1;
                    state_reg     <= S_MUL;
                end
                S_MUL:
                begin
                    if (mul_done)
                    begin
                        prod_reg      <= product;
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                        state_reg <= S_FINAL;
                end
                S_FINAL:
                begin
                    out_pos_reg  <= fin_pos;
                    out_seg_reg  <= 5'(k_reg);
                    out_inex_reg <= !fin_sat && (rem != '0);
                    out_st_reg   <= fin_sat ? ST_SATURATED : ST_OK;
                    state_reg    <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign mapped_position = out_pos_reg;
    assign segment_index   = out_seg_reg;
    assign inexact         = out_inex_reg;
    assign status          = out_st_reg;

endmodule
